### src/tcp_connection_byte_quota_filter_defines.svh
// Assertion macros for the connection quota filter.
// The asserting module must have clk and arst_n in scope.
`ifndef TCP_CONNECTION_BYTE_QUOTA_FILTER_DEFINES_SVH
`define TCP_CONNECTION_BYTE_QUOTA_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCBQF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcbqf: assertion failed");
`define TCBQF_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tcbqf: reset assertion failed");
`else
`define TCBQF_ASSERT(lbl, prop)
`define TCBQF_ASSERT_RST(lbl, prop)
`endif

`endif

### src/tcbqf_pkg.sv
`default_nettype none

package tcbqf_pkg;

	localparam int unsigned KEY_W = 96;
	localparam int unsigned REM_W = 32;
	localparam int unsigned LEN_W = 16;

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;

	typedef logic [KEY_W-1:0] conn_key_t;
	typedef logic [REM_W-1:0] remain_t;

	// table update issued by the sequencer
	typedef struct packed {
		logic ins;	// write key, zero count, set valid
		logic upd;	// write count
		logic del;	// clear valid
	} tbl_cmd_t;

endpackage

`default_nettype wire

### src/tcbqf_table.sv
`default_nettype none

module tcbqf_table
	import tcbqf_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 64,
	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output logic                  rd_vld,
	output conn_key_t             rd_key,
	output remain_t               rd_rem,
	input  tbl_cmd_t              wr_cmd,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  conn_key_t             wr_key,
	input  remain_t               wr_rem
);

	conn_key_t            key_mem [TABLE_ENTRIES];
	remain_t              rem_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_cmd.ins) begin
			key_mem[wr_idx] <= wr_key;
		end
		rd_key <= key_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (wr_cmd.ins || wr_cmd.upd) begin
			rem_mem[wr_idx] <= wr_cmd.ins ? '0 : wr_rem;
		end
		rd_rem <= rem_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rd_vld <= 1'b0;
		end else begin
			if (wr_cmd.ins) begin
				vld_q[wr_idx] <= 1'b1;
			end else if (wr_cmd.del) begin
				vld_q[wr_idx] <= 1'b0;
			end
			rd_vld <= vld_q[rd_idx];
		end
	end

endmodule

`default_nettype wire

### src/tcp_connection_byte_quota_filter.sv
// TCP connection byte-quota filter.
// Input stream (s_axis): one packet descriptor per item; tuser carries is_tcp,
// tdata carries the connection key, TCP flags and payload length.
// Output stream (m_axis): one result per input item, in order: export_packet
// and table_full.
// export_bytes is written through export_bytes_wr_en / export_bytes_wr_data
// and should only change while no item is in flight.
// A TCP item walks the whole connection table, one entry per cycle through
// the table's single registered read port, then does one read-modify-write:
// TCP item: passes through SCAN, LAST and ACT, then into the output register;
//   the next item is accepted once the sequencer is back in IDLE.
// Non-TCP item: goes from IDLE straight to ACT without walking the table.
// s_axis_tready is high only while the sequencer is idle.
// Results sit in an output register; if the receiver stalls, a finished item
// waits in its final step and no table update is made until the register
// frees up.
// Reset clears the valid bits (empty table), export_bytes and the output
// valid flag, so the table needs no initialisation after reset.
`default_nettype none
`include "tcp_connection_byte_quota_filter_defines.svh"

module tcp_connection_byte_quota_filter
	import tcbqf_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         export_bytes_wr_en,
	input  wire logic [31:0]  export_bytes_wr_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [31:0] src_addr, [63:32] dst_addr, [79:64] src_port, [95:80] dst_port,
	// [103:96] tcp_flags, [119:104] payload_len
	input  wire logic [119:0] s_axis_tdata,
	// [0] is_tcp
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [0] export_packet, [1] table_full, [7:2] zero
	output logic [7:0]        m_axis_tdata
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_ACT  = 3'd3;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_s1;
	logic             cmp_s1;
	logic             tcp_q;
	conn_key_t        key_q;
	logic [7:0]       flags_q;
	logic [LEN_W-1:0] len_q;
	remain_t          export_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	remain_t          rem_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             exp_q;
	logic             full_q;

	logic             rd_vld;
	conn_key_t        rd_key;
	remain_t          rd_rem;
	tbl_cmd_t         wr_cmd;
	logic [IDX_W-1:0] wr_idx;

	logic             in_acc;
	logic             out_free;
	logic             act_go;
	logic             is_syn;
	logic             is_fr;
	remain_t          quota;
	logic             quota_gt;
	remain_t          quota_left;
	logic             res_exp;
	logic             res_full;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign act_go        = (state_q == ST_ACT) && out_free;

	assign is_syn = |(flags_q & FLAG_SYN);
	assign is_fr  = |(flags_q & (FLAG_FIN | FLAG_RST));

	// shared quota unit: one compare and one subtract
	assign quota      = (rem_q != '0) ? rem_q : export_q;
	assign quota_gt   = quota > {{(REM_W-LEN_W){1'b0}}, len_q};
	assign quota_left = quota - {{(REM_W-LEN_W){1'b0}}, len_q};

	always_comb begin
		wr_cmd   = '0;
		wr_idx   = hit_idx_q;
		res_exp  = 1'b0;
		res_full = 1'b0;
		if (tcp_q) begin
			if (is_syn) begin
				if (!hit_q) begin
					if (free_q) begin
						wr_cmd.ins = act_go;
						wr_idx     = free_idx_q;
					end else begin
						res_full = 1'b1;
					end
				end
			end else if (is_fr) begin
				wr_cmd.del = act_go && hit_q;
			end else if (hit_q) begin
				if (quota_gt) begin
					res_exp    = 1'b1;
					wr_cmd.upd = act_go;
				end else begin
					wr_cmd.del = act_go;
				end
			end
		end
	end

	tcbqf_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (cnt_q),
		.rd_vld (rd_vld),
		.rd_key (rd_key),
		.rd_rem (rd_rem),
		.wr_cmd (wr_cmd),
		.wr_idx (wr_idx),
		.wr_key (key_q),
		.wr_rem (quota_left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			export_q <= '0;
		end else if (export_bytes_wr_en) begin
			export_q <= export_bytes_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tcp_q   <= s_axis_tuser;
			key_q   <= {s_axis_tdata[31:0], s_axis_tdata[63:32],
				s_axis_tdata[79:64], s_axis_tdata[95:80]};
			flags_q <= s_axis_tdata[103:96];
			len_q   <= s_axis_tdata[119:104];
		end
		idx_s1 <= cnt_q;
		if (cmp_s1 && rd_vld && (rd_key == key_q) && !hit_q) begin
			hit_idx_q <= idx_s1;
			rem_q     <= rd_rem;
		end
		if (cmp_s1 && !rd_vld && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (act_go) begin
			exp_q  <= res_exp;
			full_q <= res_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			cmp_s1        <= 1'b0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == ST_SCAN);
			if (cmp_s1 && rd_vld && (rd_key == key_q)) begin
				hit_q <= 1'b1;
			end
			if (cmp_s1 && !rd_vld) begin
				free_q <= 1'b1;
			end
			if (act_go) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= s_axis_tuser ? ST_SCAN : ST_ACT;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tdata = {6'b0, full_q, exp_q};

	`TCBQF_ASSERT(a_one_item, in_acc |=> !s_axis_tready)
	`TCBQF_ASSERT(a_out_from_act, $rose(m_axis_tvalid) |-> $past(state_q) == ST_ACT)
	`TCBQF_ASSERT(a_ins_needs_miss, wr_cmd.ins |-> !hit_q && free_q && tcp_q)
	`TCBQF_ASSERT(a_wr_only_act, (wr_cmd.ins || wr_cmd.upd || wr_cmd.del) |-> act_go)
	`TCBQF_ASSERT_RST(a_rst_out, !arst_n |=> !m_axis_tvalid)

endmodule

`default_nettype wire
